@@ rtl/core/tvf_pkg.sv @@
`timescale 1ns / 1ps
// tvf_pkg: shared widths, register indexes and payload types for the volume fade ramp.
// No dependencies.
package tvf_pkg;

	localparam int TIME_BITS   = 24;
	localparam int VOLUME_BITS = 16;
	localparam int CFG_IDX_BITS = 3;
	localparam int CFG_DATA_BITS = TIME_BITS;
	localparam int PROD_BITS   = TIME_BITS + VOLUME_BITS;

	// configuration register indexes
	localparam logic [CFG_IDX_BITS-1:0] REG_START_TIME  = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_END_TIME    = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_TARGET_VOL  = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_END_ACTION  = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] REG_REMOVE_DONE = 3'd4;

	// player status and action codes
	localparam logic [1:0] STATUS_PLAYING = 2'd0;
	localparam logic [1:0] STATUS_BLOCKED = 2'd1;
	localparam logic [1:0] ACTION_NONE    = 2'd0;
	localparam logic [1:0] ACTION_RSVD    = 2'd3;

	localparam logic [VOLUME_BITS-1:0] VOLUME_FULL = VOLUME_BITS'(32768);

	typedef struct packed {
		logic [TIME_BITS-1:0]   play_position;
		logic [1:0]             player_status;
		logic [VOLUME_BITS-1:0] source_volume;
	} tvf_in_t;

	typedef struct packed {
		logic                   volume_write;
		logic [VOLUME_BITS-1:0] volume_value;
		logic [1:0]             action;
		logic                   keep;
		logic                   is_active;
	} tvf_out_t;

endpackage

@@ rtl/core/timed_volume_fade_ramp.sv @@
`timescale 1ns / 1ps
// timed_volume_fade_ramp: timed linear volume fade, one result item per tick item.
// An accepted tick goes through PREP, MUL, DIV and FIN while a fade is active with a nonzero
// duration (the serial divider makes one quotient bit per cycle in DIV); PREP and FIN otherwise.
// A new tick is taken only after the previous one has left FIN; in_ready is high
// only while the sequencer is idle. A result may wait in the output register.
// Reset: asynchronous, clears the fade state and loads register defaults.
// Depends on tvf_pkg and tvf_div.
module timed_volume_fade_ramp (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  tvf_pkg::tvf_in_t                   in_data,
	output logic                               out_valid,
	input  logic                               out_ready,
	output tvf_pkg::tvf_out_t                  out_data,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [tvf_pkg::CFG_IDX_BITS-1:0]   cfg_index,
	input  logic [tvf_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

	localparam int VB = tvf_pkg::VOLUME_BITS;
	localparam int TB = tvf_pkg::TIME_BITS;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_PREP = 3'd1;
	localparam logic [2:0] ST_MUL  = 3'd2;
	localparam logic [2:0] ST_DIV  = 3'd3;
	localparam logic [2:0] ST_FIN  = 3'd4;

	logic [2:0]    state_q;

	// configuration
	logic [TB-1:0] start_time_q;
	logic [TB-1:0] end_time_q;
	logic [VB-1:0] target_q;
	logic [1:0]    end_action_q;
	logic          remove_q;

	// fade state
	logic          active_q;
	logic [VB-1:0] start_vol_q;
	logic [VB-1:0] last_vol_q;

	// per-item working registers
	logic [TB-1:0] pos_q;
	logic          running_q;
	logic [TB-1:0] elapsed_q;
	logic [TB-1:0] dur_q;
	logic [VB-1:0] diff_q;
	logic          down_q;
	logic          zero_dur_q;

	tvf_pkg::tvf_out_t out_q;
	logic              out_valid_q;

	logic          in_acc;
	logic          running_in;
	logic          arm;
	logic          div_start;
	logic          div_busy;
	logic [VB-1:0] quotient;
	logic [VB-1:0] value;
	logic          out_free;
	logic          finish;
	tvf_pkg::tvf_out_t res;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_acc    = in_valid & in_ready;
	assign cfg_ready = 1'b1;
	assign out_free  = ~out_valid_q | out_ready;

	assign running_in = (in_data.player_status == tvf_pkg::STATUS_PLAYING) ||
	                    (in_data.player_status == tvf_pkg::STATUS_BLOCKED);
	assign arm = ~active_q & running_in & (in_data.play_position >= start_time_q);

	assign div_start = (state_q == ST_MUL);

	tvf_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.diff     (diff_q),
		.elapsed  (elapsed_q),
		.divisor  (dur_q),
		.busy     (div_busy),
		.quotient (quotient)
	);

	always_comb begin
		if (zero_dur_q) begin
			value = target_q;
		end else if (down_q) begin
			value = start_vol_q - quotient;
		end else begin
			value = start_vol_q + quotient;
		end
	end

	assign finish = active_q & running_q & (pos_q > end_time_q);

	always_comb begin
		res.volume_write = 1'b0;
		res.volume_value = '0;
		res.action       = tvf_pkg::ACTION_NONE;
		res.keep         = 1'b1;
		res.is_active    = active_q;
		if (active_q && value != last_vol_q) begin
			res.volume_write = 1'b1;
			res.volume_value = value;
		end
		if (finish) begin
			res.volume_write = 1'b1;
			res.volume_value = target_q;
			res.action       = (end_action_q == tvf_pkg::ACTION_RSVD) ?
			                   tvf_pkg::ACTION_NONE : end_action_q;
			res.keep         = remove_q;
			res.is_active    = 1'b0;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_acc) state_q <= ST_PREP;
				end
				ST_PREP: begin
					// nothing to interpolate when inactive or the end time is not after the start time
					if (active_q && (end_time_q > start_time_q)) state_q <= ST_MUL;
					else state_q <= ST_FIN;
				end
				ST_MUL: begin
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (!div_busy) state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (out_free) state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// fade state and config
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q     <= 1'b0;
			start_vol_q  <= '0;
			last_vol_q   <= '0;
			start_time_q <= '0;
			end_time_q   <= '0;
			target_q     <= tvf_pkg::VOLUME_FULL;
			end_action_q <= tvf_pkg::ACTION_NONE;
			remove_q     <= 1'b1;
		end else begin
			if (in_acc && arm) begin
				active_q    <= 1'b1;
				start_vol_q <= in_data.source_volume;
				last_vol_q  <= in_data.source_volume;
			end
			if (state_q == ST_FIN && out_free) begin
				if (active_q && value != last_vol_q) last_vol_q <= value;
				if (finish) active_q <= 1'b0;
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					tvf_pkg::REG_START_TIME:  start_time_q <= cfg_data[TB-1:0];
					tvf_pkg::REG_END_TIME:    end_time_q   <= cfg_data[TB-1:0];
					tvf_pkg::REG_TARGET_VOL:  target_q     <= cfg_data[VB-1:0];
					tvf_pkg::REG_END_ACTION:  end_action_q <= cfg_data[1:0];
					tvf_pkg::REG_REMOVE_DONE: remove_q     <= cfg_data[0];
					default: begin
					end
				endcase
			end
		end
	end

	// item working registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			pos_q     <= in_data.play_position;
			running_q <= running_in;
		end
		if (state_q == ST_PREP) begin
			zero_dur_q <= (end_time_q <= start_time_q);
			dur_q      <= end_time_q - start_time_q;
			if (pos_q <= start_time_q) begin
				elapsed_q <= '0;
			end else if (pos_q >= end_time_q) begin
				elapsed_q <= end_time_q - start_time_q;
			end else begin
				elapsed_q <= pos_q - start_time_q;
			end
			down_q <= (start_vol_q > target_q);
			diff_q <= (start_vol_q > target_q) ? (start_vol_q - target_q) :
			                                     (target_q - start_vol_q);
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_FIN && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_FIN && out_free) out_q <= res;
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

@@ rtl/core/tvf_div.sv @@
`timescale 1ns / 1ps
// tvf_div: multiply-then-divide unit, one restoring quotient bit per cycle.
// Depends on tvf_pkg.
module tvf_div (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [tvf_pkg::VOLUME_BITS-1:0] diff,
	input  logic [tvf_pkg::TIME_BITS-1:0]   elapsed,
	input  logic [tvf_pkg::TIME_BITS-1:0]   divisor,
	output logic                            busy,
	output logic [tvf_pkg::VOLUME_BITS-1:0] quotient
);

	localparam int CNT_BITS = $clog2(tvf_pkg::VOLUME_BITS + 1);

	logic [tvf_pkg::PROD_BITS-1:0]   prod;
	logic [tvf_pkg::TIME_BITS-1:0]   rem_q;
	logic [tvf_pkg::VOLUME_BITS-1:0] quo_q;
	logic [CNT_BITS-1:0]             cnt_q;
	logic [tvf_pkg::TIME_BITS:0]     shifted;
	logic [tvf_pkg::TIME_BITS:0]     diffd;
	logic                            ge;

	// elapsed <= divisor, so the quotient fits in VOLUME_BITS and the
	// upper product bits start below the divisor
	assign prod = tvf_pkg::PROD_BITS'(diff) * tvf_pkg::PROD_BITS'(elapsed);

	assign shifted = {rem_q, quo_q[tvf_pkg::VOLUME_BITS-1]};
	assign diffd   = shifted - {1'b0, divisor};
	assign ge      = ~diffd[tvf_pkg::TIME_BITS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CNT_BITS'(tvf_pkg::VOLUME_BITS);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= prod[tvf_pkg::PROD_BITS-1:tvf_pkg::VOLUME_BITS];
			quo_q <= prod[tvf_pkg::VOLUME_BITS-1:0];
		end else if (cnt_q != '0) begin
			rem_q <= ge ? diffd[tvf_pkg::TIME_BITS-1:0] : shifted[tvf_pkg::TIME_BITS-1:0];
			quo_q <= {quo_q[tvf_pkg::VOLUME_BITS-2:0], ge};
		end
	end

	assign busy     = (cnt_q != '0);
	assign quotient = quo_q;

endmodule

@@ tb/sv/tvf_fade_checker.sv @@
`timescale 1ns / 1ps
// tvf_fade_checker: tracks the fade ramp's registers and state from the channels it watches,
// works out each tick's result item and compares it with what the block returns.
// Depends on tvf_pkg.
module tvf_fade_checker (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	input  logic                              in_ready,
	input  tvf_pkg::tvf_in_t                  in_data,
	input  logic                              out_valid,
	input  logic                              out_ready,
	input  tvf_pkg::tvf_out_t                 out_data,
	input  logic                              cfg_valid,
	input  logic                              cfg_ready,
	input  logic [tvf_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [tvf_pkg::CFG_DATA_BITS-1:0] cfg_data,
	output int                                fail_count,
	output int                                pending,
	output int                                quiet_cycles
);

	// register copies
	logic [tvf_pkg::TIME_BITS-1:0]   fade_begin;
	logic [tvf_pkg::TIME_BITS-1:0]   fade_finish;
	logic [tvf_pkg::VOLUME_BITS-1:0] vol_goal;
	logic [1:0]                      finish_act;
	logic                            drop_flag;

	// fade state
	logic                            fade_on;
	logic [tvf_pkg::VOLUME_BITS-1:0] vol_at_start;
	logic [tvf_pkg::VOLUME_BITS-1:0] vol_applied;

	tvf_pkg::tvf_out_t volume_results_due[$];

	function automatic logic [tvf_pkg::VOLUME_BITS-1:0] ramp_level(
		input logic [tvf_pkg::TIME_BITS-1:0] pos);
		logic [tvf_pkg::TIME_BITS-1:0]   span;
		logic [tvf_pkg::TIME_BITS-1:0]   elapsed;
		logic [tvf_pkg::VOLUME_BITS-1:0] gap;
		logic [tvf_pkg::PROD_BITS-1:0]   step;
		if (fade_finish <= fade_begin)
			return vol_goal;
		span = fade_finish - fade_begin;
		if (pos <= fade_begin)
			elapsed = '0;
		else if (pos >= fade_finish)
			elapsed = span;
		else
			elapsed = pos - fade_begin;
		if (vol_at_start > vol_goal) begin
			gap = vol_at_start - vol_goal;
			step = (tvf_pkg::PROD_BITS'(gap) * elapsed) / span;
			return vol_at_start - step[tvf_pkg::VOLUME_BITS-1:0];
		end
		gap = vol_goal - vol_at_start;
		step = (tvf_pkg::PROD_BITS'(gap) * elapsed) / span;
		return vol_at_start + step[tvf_pkg::VOLUME_BITS-1:0];
	endfunction

	function automatic tvf_pkg::tvf_out_t advance_fade(input tvf_pkg::tvf_in_t tick);
		logic                            running;
		logic [tvf_pkg::VOLUME_BITS-1:0] lvl;
		tvf_pkg::tvf_out_t               r;
		running = (tick.player_status == tvf_pkg::STATUS_PLAYING) ||
			(tick.player_status == tvf_pkg::STATUS_BLOCKED);
		r = '0;
		r.keep = 1'b1;
		if (!fade_on && running && tick.play_position >= fade_begin) begin
			fade_on = 1'b1;
			vol_at_start = tick.source_volume;
			vol_applied = tick.source_volume;
		end
		if (fade_on) begin
			lvl = ramp_level(tick.play_position);
			if (lvl != vol_applied) begin
				vol_applied = lvl;
				r.volume_write = 1'b1;
				r.volume_value = lvl;
			end
			// finishing overrides any interpolation write in the same tick
			if (running && tick.play_position > fade_finish) begin
				r.volume_write = 1'b1;
				r.volume_value = vol_goal;
				r.action = (finish_act == tvf_pkg::ACTION_RSVD) ?
					tvf_pkg::ACTION_NONE : finish_act;
				r.keep = drop_flag;
				fade_on = 1'b0;
			end
		end
		r.is_active = fade_on;
		return r;
	endfunction

	task automatic check_field(input string what, input logic [31:0] want,
		input logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		tvf_pkg::tvf_out_t due;
		if (!arst_n) begin
			fade_begin = '0;
			fade_finish = '0;
			vol_goal = tvf_pkg::VOLUME_FULL;
			finish_act = tvf_pkg::ACTION_NONE;
			drop_flag = 1'b1;
			fade_on = 1'b0;
			vol_at_start = '0;
			vol_applied = '0;
			volume_results_due.delete();
			fail_count = 0;
			pending = 0;
			quiet_cycles = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					tvf_pkg::REG_START_TIME: begin
						fade_begin = cfg_data[tvf_pkg::TIME_BITS-1:0];
					end
					tvf_pkg::REG_END_TIME: begin
						fade_finish = cfg_data[tvf_pkg::TIME_BITS-1:0];
					end
					tvf_pkg::REG_TARGET_VOL: begin
						vol_goal = cfg_data[tvf_pkg::VOLUME_BITS-1:0];
					end
					tvf_pkg::REG_END_ACTION: begin
						finish_act = cfg_data[1:0];
					end
					tvf_pkg::REG_REMOVE_DONE: begin
						drop_flag = cfg_data[0];
					end
					default: begin
					end
				endcase
			end
			if (in_valid && in_ready)
				volume_results_due.push_back(advance_fade(in_data));
			if (out_valid && out_ready) begin
				if (volume_results_due.size() == 0) begin
					$display("%0t: result item with none expected, got %h", $time, out_data);
					fail_count++;
				end else begin
					due = volume_results_due.pop_front();
					check_field("volume_write", due.volume_write, out_data.volume_write);
					check_field("volume_value", due.volume_value, out_data.volume_value);
					check_field("action", due.action, out_data.action);
					check_field("keep", due.keep, out_data.keep);
					check_field("is_active", due.is_active, out_data.is_active);
				end
			end
			if ((cfg_valid && cfg_ready) || (in_valid && in_ready) || (out_valid && out_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			pending = volume_results_due.size();
		end
	end

endmodule

@@ tb/sv/tb_timed_volume_fade_ramp.sv @@
`timescale 1ns / 1ps
// tb_timed_volume_fade_ramp: drives ticks and register writes into the fade ramp, with
// random idling on both channels; tvf_fade_checker predicts and compares the results.
// Depends on tvf_pkg, tvf_fade_checker and the block itself.
module tb_timed_volume_fade_ramp;

	localparam logic [1:0] STATUS_OTHER = 2'd2;
	localparam logic [1:0] STATUS_RSVD  = 2'd3;
	localparam logic [1:0] ACTION_PAUSE = 2'd1;
	localparam logic [1:0] ACTION_STOP  = 2'd2;
	localparam logic [tvf_pkg::CFG_IDX_BITS-1:0] REG_UNUSED = 3'd7;
	localparam int ITEMS_TOTAL = 950;
	localparam int MODE_ITEMS  = 317;
	localparam int HOLD_CYCLES = 300;
	localparam int QUIET_LIMIT = 4000;

	logic                              clk;
	logic                              arst_n;
	logic                              in_valid;
	logic                              in_ready;
	tvf_pkg::tvf_in_t                  in_data;
	logic                              out_valid;
	logic                              out_ready;
	tvf_pkg::tvf_out_t                 out_data;
	logic                              cfg_valid;
	logic                              cfg_ready;
	logic [tvf_pkg::CFG_IDX_BITS-1:0]  cfg_index;
	logic [tvf_pkg::CFG_DATA_BITS-1:0] cfg_data;

	int fail_count;
	int pending;
	int quiet_cycles;

	int items_sent = 0;
	int send_idle_pct = 26;
	int recv_idle_pct = 55;
	int hold_requests = 0;

	timed_volume_fade_ramp dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	tvf_fade_checker checker_i (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.in_data      (in_data),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_data     (out_data),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.fail_count   (fail_count),
		.pending      (pending),
		.quiet_cycles (quiet_cycles)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// result side: random stalls, plus long hold-offs on request
	initial begin
		int hold_left;
		int holds_served;
		hold_left = 0;
		holds_served = 0;
		out_ready <= 1'b0;
		forever begin
			@(negedge clk);
			if (holds_served != hold_requests) begin
				holds_served = hold_requests;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	initial begin
		while (quiet_cycles < QUIET_LIMIT)
			@(negedge clk);
		$display("tb_timed_volume_fade_ramp: done, errors");
		$finish;
	end

	function automatic logic [tvf_pkg::VOLUME_BITS-1:0] pick_level();
		case ($urandom_range(0, 4))
			0: return '0;
			1: return tvf_pkg::VOLUME_FULL;
			2: return tvf_pkg::VOLUME_BITS'($urandom);
			default: return tvf_pkg::VOLUME_BITS'($urandom_range(0, 32768));
		endcase
	endfunction

	function automatic logic [1:0] pick_status(input int running_pct);
		if ($urandom_range(99) < running_pct)
			return $urandom_range(1) ? tvf_pkg::STATUS_BLOCKED : tvf_pkg::STATUS_PLAYING;
		return $urandom_range(1) ? STATUS_RSVD : STATUS_OTHER;
	endfunction

	task automatic send_tick(input logic [tvf_pkg::TIME_BITS-1:0] pos,
		input logic [1:0] status, input logic [tvf_pkg::VOLUME_BITS-1:0] vol);
		if (items_sent < MODE_ITEMS) begin
			send_idle_pct = 26;
			recv_idle_pct = 55;
		end else if (items_sent < 2 * MODE_ITEMS) begin
			send_idle_pct = 55;
			recv_idle_pct = 26;
		end else begin
			send_idle_pct = 0;
			recv_idle_pct = 0;
		end
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= '{play_position: pos, player_status: status, source_volume: vol};
		do
			@(posedge clk);
		while (!in_ready);
		items_sent++;
	endtask

	task automatic write_reg(input logic [tvf_pkg::CFG_IDX_BITS-1:0] idx,
		input logic [tvf_pkg::CFG_DATA_BITS-1:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do
			@(posedge clk);
		while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// narrow registers get junk in the unused upper data bits
	task automatic load_fade(input logic [tvf_pkg::TIME_BITS-1:0] t0,
		input logic [tvf_pkg::TIME_BITS-1:0] t1, input logic [tvf_pkg::VOLUME_BITS-1:0] goal,
		input logic [1:0] act, input logic rm);
		write_reg(tvf_pkg::REG_START_TIME, t0);
		write_reg(tvf_pkg::REG_END_TIME, t1);
		write_reg(tvf_pkg::REG_TARGET_VOL, {8'($urandom), goal});
		write_reg(tvf_pkg::REG_END_ACTION, {22'($urandom), act});
		write_reg(tvf_pkg::REG_REMOVE_DONE, {23'($urandom), rm});
	endtask

	// stop offering, let every result drain, then give the pipeline time to go idle
	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (24) @(negedge clk);
	endtask

	initial begin
		longint win_lo;
		longint win_hi;
		longint span;
		longint stride;
		longint pos;
		logic [tvf_pkg::TIME_BITS-1:0] t0;
		logic [tvf_pkg::TIME_BITS-1:0] t1;
		int n;
		int holds_done;

		arst_n <= 1'b0;
		in_valid <= 1'b0;
		in_data <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		holds_done = 0;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		// register defaults: zero-length window at 0, full target
		send_tick(0, tvf_pkg::STATUS_PLAYING, 0);
		send_tick(5, tvf_pkg::STATUS_BLOCKED, 16'h1234);
		settle();

		load_fade(100, 1100, 0, ACTION_PAUSE, 1'b0);
		write_reg(REG_UNUSED, 24'hFFFFFF);
		send_tick(500, STATUS_OTHER, 1000);
		send_tick(24'hFFFFFF, STATUS_RSVD, 16'hFFFF);
		send_tick(50, tvf_pkg::STATUS_PLAYING, 16'h4000);
		send_tick(100, tvf_pkg::STATUS_PLAYING, 16'hFFFF);
		send_tick(600, tvf_pkg::STATUS_BLOCKED, 0);
		send_tick(20, tvf_pkg::STATUS_PLAYING, 0);       // new cycle while active
		send_tick(1100, tvf_pkg::STATUS_PLAYING, 0);
		send_tick(5000, STATUS_OTHER, 0);                // past end, but not running
		send_tick(1101, tvf_pkg::STATUS_BLOCKED, 0);
		settle();

		// end before start: arm and finish in one tick
		load_fade(5000, 1000, 16'hFFFF, ACTION_STOP, 1'b1);
		send_tick(4999, tvf_pkg::STATUS_PLAYING, 16'h8000);
		send_tick(6000, tvf_pkg::STATUS_PLAYING, 16'h8000);
		settle();

		load_fade(24'hFFFFFF, 24'hFFFFFF, 0, tvf_pkg::ACTION_RSVD, 1'b0);
		send_tick(24'hFFFFFE, tvf_pkg::STATUS_PLAYING, 0);
		send_tick(24'hFFFFFF, tvf_pkg::STATUS_BLOCKED, 16'h8000);
		send_tick(0, STATUS_OTHER, 0);
		settle();

		load_fade(0, 24'hFFFFFF, tvf_pkg::VOLUME_FULL, tvf_pkg::ACTION_NONE, 1'b1);
		send_tick(24'h800000, tvf_pkg::STATUS_PLAYING, 16'h7FFF);
		send_tick(24'hFFFFFF, tvf_pkg::STATUS_PLAYING, 0);
		settle();

		while (items_sent < ITEMS_TOTAL) begin
			case ($urandom_range(0, 9))
				0: begin
					t0 = 0;
					t1 = 24'hFFFFFF;
				end
				1: begin
					t0 = tvf_pkg::TIME_BITS'(24'hFFFFFF - $urandom_range(0, 200));
					t1 = 24'hFFFFFF;
				end
				2: begin
					t0 = tvf_pkg::TIME_BITS'($urandom_range(100, 3000));
					t1 = tvf_pkg::TIME_BITS'(t0 - $urandom_range(1, 100));
				end
				3: begin
					t0 = tvf_pkg::TIME_BITS'($urandom_range(0, 2000));
					t1 = t0;
				end
				4: begin
					t0 = tvf_pkg::TIME_BITS'($urandom);
					t1 = tvf_pkg::TIME_BITS'($urandom);
				end
				default: begin
					t0 = tvf_pkg::TIME_BITS'($urandom_range(0, 3000));
					t1 = tvf_pkg::TIME_BITS'(t0 + $urandom_range(1, 4000));
				end
			endcase
			load_fade(t0, t1, pick_level(), 2'($urandom), 1'($urandom));

			// once per idling mode, stall the result side while ticks keep coming
			if (holds_done < 3 && items_sent >= holds_done * MODE_ITEMS + 40) begin
				hold_requests++;
				holds_done++;
			end

			win_lo = longint'((t0 < t1) ? t0 : t1);
			win_hi = longint'((t0 < t1) ? t1 : t0);
			span = win_hi - win_lo;
			repeat ($urandom_range(1, 3)) begin
				stride = span / longint'($urandom_range(3, 10)) + 1;
				pos = win_lo - longint'($urandom_range(0, int'(span >> 2) + 3));
				if (pos < 0)
					pos = 0;
				n = 0;
				while (pos <= win_hi && n < 16) begin
					send_tick(tvf_pkg::TIME_BITS'(pos), pick_status(90), pick_level());
					n++;
					if ($urandom_range(99) < 8)
						pos = longint'($urandom_range(0, int'(t0)));
					else
						pos = pos + longint'($urandom_range(1, int'(stride * 2)));
				end
				if (win_hi < 24'hFFFFFF) begin
					pos = win_hi + 1 + longint'($urandom_range(0, 40));
					if (pos > 24'hFFFFFF)
						pos = 24'hFFFFFF;
					send_tick(tvf_pkg::TIME_BITS'(pos), pick_status(100), pick_level());
				end
			end
			repeat ($urandom_range(0, 4))
				send_tick(tvf_pkg::TIME_BITS'($urandom), 2'($urandom),
					tvf_pkg::VOLUME_BITS'($urandom));
			settle();
		end

		repeat (40) @(negedge clk);
		if (fail_count == 0 && pending == 0)
			$display("tb_timed_volume_fade_ramp: done, clean");
		else
			$display("tb_timed_volume_fade_ramp: done, errors");
		$finish;
	end

endmodule
